### rtl/core/msidir_pkg.sv
package msidir_pkg;

    localparam int NODES      = 8;
    localparam int NODE_BITS  = 3;
    localparam int ENTRIES    = 256;
    localparam int ENTRY_BITS = 8;
    localparam int COUNT_BITS = 8;

    localparam logic [1:0] NS_INVALID = 2'd0;
    localparam logic [1:0] NS_OWNER   = 2'd1;
    localparam logic [1:0] NS_SHARED  = 2'd2;

    localparam logic REQ_FETCH   = 1'b0;
    localparam logic REQ_RELEASE = 1'b1;

    localparam logic [1:0] MODE_READ  = 2'd0;
    localparam logic [1:0] MODE_WRITE = 2'd1;

    localparam logic [1:0] ERR_NONE     = 2'd0;
    localparam logic [1:0] ERR_NO_COPY  = 2'd1;
    localparam logic [1:0] ERR_INVALID  = 2'd2;
    localparam logic [1:0] ERR_LIMIT    = 2'd3;

    typedef enum logic {
        FSM_IDLE,
        FSM_RUN
    } fsm_t;

    typedef struct packed {
        logic                  req_type;
        logic [ENTRY_BITS-1:0] data_id;
        logic [NODE_BITS-1:0]  requester_node;
        logic [1:0]            fetch_mode;
        logic [NODES-1:0]      commit_mask;
    } req_t;

    typedef struct packed {
        logic                  copy_needed;
        logic [NODES-1:0]      copy_sources;
        logic                  copy_no_read;
        logic [NODES-1:0]      copy_targets;
        logic [1:0]            node_state;
        logic [COUNT_BITS-1:0] ref_count;
        logic [1:0]            error_code;
    } rsp_t;

    typedef struct packed {
        logic [NODES-1:0][1:0]            states;
        logic [NODES-1:0][COUNT_BITS-1:0] counts;
    } dir_entry_t;

    function automatic dir_entry_t reset_entry();
        dir_entry_t e;
        e.states    = '0;
        e.counts    = '0;
        e.states[0] = NS_OWNER;
        return e;
    endfunction

endpackage

### rtl/core/msi_directory_controller_top.sv
// Channel   Handshake                 Payload           Width
// request   start & !busy -> transfer req    (req_t)      22
// result    done, one cycle, no stall result (rsp_t)      30
//
// Each request is a read-modify-write: the accept edge reads the directory entry from
// synchronous memory, then in state FSM_RUN the updated entry is written back and the
// result registered, which shows on result with done for one cycle.
// busy is high for one cycle after each accept, so no new request is taken until the
// previous one has written its directory entry back.
// Reset marks every entry unwritten; such entries read as node 0 owner, counts zero.
module msi_directory_controller_top (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  msidir_pkg::req_t  req,
    output logic              done,
    output msidir_pkg::rsp_t  result
);

    msidir_pkg::fsm_t       state_reg;
    msidir_pkg::fsm_t       state_next;
    msidir_pkg::req_t       req_reg;
    msidir_pkg::rsp_t       result_reg;
    logic                   done_reg;
    logic                   done_next;
    logic                   accept;
    logic                   wr_en;
    msidir_pkg::dir_entry_t rd_data;
    msidir_pkg::dir_entry_t wr_data;
    msidir_pkg::rsp_t       rsp;

    assign accept = start && !busy;

    always_comb
    begin
        case (state_reg)
            msidir_pkg::FSM_IDLE: state_next = accept ? msidir_pkg::FSM_RUN
                                                      : msidir_pkg::FSM_IDLE;
            msidir_pkg::FSM_RUN:  state_next = msidir_pkg::FSM_IDLE;
            default:              state_next = msidir_pkg::FSM_IDLE;
        endcase
    end

    always_comb
    begin
        case (state_reg)
            msidir_pkg::FSM_IDLE:
            begin
                busy  = 1'b0;
                wr_en = 1'b0;
            end
            msidir_pkg::FSM_RUN:
            begin
                busy  = 1'b1;
                wr_en = 1'b1;
            end
            default:
            begin
                busy  = 1'b1;
                wr_en = 1'b0;
            end
        endcase
        done_next = wr_en;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= msidir_pkg::FSM_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg <= req;
        end
        if (wr_en)
        begin
            result_reg <= rsp;
        end
    end

    msidir_mem u_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (accept),
        .rd_addr (req.data_id),
        .wr_en   (wr_en),
        .wr_addr (req_reg.data_id),
        .wr_data (wr_data),
        .rd_data (rd_data)
    );

    msidir_update u_update (
        .req       (req_reg),
        .entry_in  (rd_data),
        .entry_out (wr_data),
        .rsp       (rsp)
    );

    assign done   = done_reg;
    assign result = result_reg;

endmodule

### rtl/core/msidir_mem.sv
module msidir_mem (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                rd_en,
    input  logic [msidir_pkg::ENTRY_BITS-1:0]   rd_addr,
    input  logic                                wr_en,
    input  logic [msidir_pkg::ENTRY_BITS-1:0]   wr_addr,
    input  msidir_pkg::dir_entry_t              wr_data,
    output msidir_pkg::dir_entry_t              rd_data
);

    msidir_pkg::dir_entry_t             mem [msidir_pkg::ENTRIES];
    logic [msidir_pkg::ENTRIES-1:0]     valid_reg;
    msidir_pkg::dir_entry_t             rd_q_reg;
    logic                               rd_valid_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_q_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

    // unwritten entries read as the reset state
    assign rd_data = rd_valid_reg ? rd_q_reg : msidir_pkg::reset_entry();

endmodule

### rtl/core/msidir_update.sv
module msidir_update (
    input  msidir_pkg::req_t        req,
    input  msidir_pkg::dir_entry_t  entry_in,
    output msidir_pkg::dir_entry_t  entry_out,
    output msidir_pkg::rsp_t        rsp
);

    logic [msidir_pkg::NODE_BITS-1:0]  r;
    logic [1:0]                        ls;
    logic [msidir_pkg::COUNT_BITS-1:0] cnt;
    logic                              rd;
    logic                              wr;
    logic [msidir_pkg::NODES-1:0]      src;
    logic [msidir_pkg::NODES-1:0]      tgt;

    always_comb
    begin
        r   = req.requester_node;
        ls  = entry_in.states[r];
        cnt = entry_in.counts[r];
        rd  = (req.fetch_mode != msidir_pkg::MODE_WRITE);
        wr  = (req.fetch_mode != msidir_pkg::MODE_READ);
        for (int n = 0; n < msidir_pkg::NODES; n++)
        begin
            src[n] = (entry_in.states[n] != msidir_pkg::NS_INVALID);
        end
        tgt = req.commit_mask
            & ~({{(msidir_pkg::NODES-1){1'b0}}, 1'b1} << r);

        entry_out = entry_in;
        rsp       = '0;
        rsp.error_code = msidir_pkg::ERR_NONE;

        if (req.req_type == msidir_pkg::REQ_FETCH)
        begin
            if (cnt == {msidir_pkg::COUNT_BITS{1'b1}})
            begin
                rsp.error_code = msidir_pkg::ERR_LIMIT;
            end
            else if (ls == msidir_pkg::NS_OWNER || (ls == msidir_pkg::NS_SHARED && !wr))
            begin
                entry_out.counts[r] = cnt + msidir_pkg::COUNT_BITS'(1);
            end
            else if (ls == msidir_pkg::NS_SHARED)
            begin
                // upgrade: requester owns, other sharers drop
                for (int n = 0; n < msidir_pkg::NODES; n++)
                begin
                    if (entry_in.states[n] == msidir_pkg::NS_SHARED)
                    begin
                        entry_out.states[n] = (msidir_pkg::NODE_BITS'(n) == r)
                                            ? msidir_pkg::NS_OWNER
                                            : msidir_pkg::NS_INVALID;
                    end
                end
                entry_out.counts[r] = cnt + msidir_pkg::COUNT_BITS'(1);
            end
            else if (src == '0)
            begin
                rsp.error_code = msidir_pkg::ERR_NO_COPY;
            end
            else
            begin
                for (int n = 0; n < msidir_pkg::NODES; n++)
                begin
                    if (wr)
                    begin
                        entry_out.states[n] = msidir_pkg::NS_INVALID;
                    end
                    else if (entry_in.states[n] != msidir_pkg::NS_INVALID)
                    begin
                        entry_out.states[n] = msidir_pkg::NS_SHARED;
                    end
                end
                entry_out.states[r] = wr ? msidir_pkg::NS_OWNER : msidir_pkg::NS_SHARED;
                entry_out.counts[r] = cnt + msidir_pkg::COUNT_BITS'(1);
                rsp.copy_needed  = 1'b1;
                rsp.copy_sources = src;
                rsp.copy_no_read = !rd;
            end
        end
        else
        begin
            if (ls == msidir_pkg::NS_INVALID)
            begin
                rsp.error_code = msidir_pkg::ERR_INVALID;
            end
            else if (cnt == '0)
            begin
                rsp.error_code = msidir_pkg::ERR_LIMIT;
            end
            else
            begin
                if (tgt != '0)
                begin
                    for (int n = 0; n < msidir_pkg::NODES; n++)
                    begin
                        if (req.commit_mask[n])
                        begin
                            entry_out.states[n] = msidir_pkg::NS_SHARED;
                        end
                    end
                    entry_out.states[r] = msidir_pkg::NS_SHARED;
                end
                entry_out.counts[r] = cnt - msidir_pkg::COUNT_BITS'(1);
                rsp.copy_targets    = tgt;
            end
        end

        rsp.node_state = entry_out.states[r];
        rsp.ref_count  = entry_out.counts[r];
    end

endmodule
